>>> hdl/cdac_pkg.sv
// Shared types, sizes, register codes and reset values for the card door
// access controller. No dependencies; every other file imports this package.
package cdac_pkg;

    localparam int DOOR_COUNT   = 3;
    localparam int USER_ENTRIES = 3;
    localparam int TIME_BITS    = 32;

    localparam int UID_W       = 32;
    localparam int UID_SLOTS   = 3;
    localparam int DOOR_CODE_W = 2;
    localparam int CLOSE_W     = 3;
    localparam int MS_W        = 16;
    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [MS_W-1:0]                  RST_SCAN_INTERVAL = 16'd1000;
    localparam logic [MS_W-1:0]                  RST_OPEN_TIME     = 16'd5000;
    localparam logic [UID_W-1:0]                 RST_UID_A         = 32'hED896D05;
    localparam logic [UID_W-1:0]                 RST_UID_B         = 32'hCCEF4B06;
    localparam logic [UID_W-1:0]                 RST_UID_C         = 32'h11223344;
    localparam logic [UID_SLOTS*DOOR_CODE_W-1:0] RST_DOOR_MAP      = 6'd36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MONITOR_ENABLE = 3'd0,
        CFG_SCAN_INTERVAL  = 3'd1,
        CFG_OPEN_TIME      = 3'd2,
        CFG_USER_UID_A     = 3'd3,
        CFG_USER_UID_B     = 3'd4,
        CFG_USER_UID_C     = 3'd5,
        CFG_USER_DOOR_MAP  = 3'd6
    } t_cfg_reg;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic                                 monitor_enable;
        logic [MS_W-1:0]                      scan_interval_ms;
        logic [MS_W-1:0]                      open_time_ms;
        logic [UID_SLOTS-1:0][UID_W-1:0]      user_uid;
        logic [UID_SLOTS*DOOR_CODE_W-1:0]     user_door_map;
    } t_cfg;

    typedef struct packed {
        logic [NOW_W-1:0] now_ms;
        logic             read_ok;
        logic [UID_W-1:0] card_uid;
    } t_in_item;

    typedef struct packed {
        logic [CLOSE_W-1:0]     close_mask;
        logic                   open_valid;
        logic [DOOR_CODE_W-1:0] open_door;
        logic                   scan_taken;
    } t_result;

    typedef struct packed {
        logic [DOOR_COUNT-1:0][TIME_BITS-1:0] deadline;
        t_time                                last_scan;
    } t_state;

endpackage

>>> hdl/cdac_in_if.sv
// Input channel: one processing call (time, read outcome, card UID).
// Depends on cdac_pkg for field widths.
interface cdac_in_if;
    import cdac_pkg::*;

    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now_ms;
    logic             read_ok;
    logic [UID_W-1:0] card_uid;

    modport source (output valid, now_ms, read_ok, card_uid, input ready);
    modport sink   (input valid, now_ms, read_ok, card_uid, output ready);
endinterface

>>> hdl/cdac_out_if.sv
// Output channel: one result per call (door closes, door open, scan flag).
// Depends on cdac_pkg for field widths.
interface cdac_out_if;
    import cdac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CLOSE_W-1:0]     close_mask;
    logic                   open_valid;
    logic [DOOR_CODE_W-1:0] open_door;
    logic                   scan_taken;

    modport source (output valid, close_mask, open_valid, open_door, scan_taken,
                    input ready);
    modport sink   (input valid, close_mask, open_valid, open_door, scan_taken,
                    output ready);
endinterface

>>> hdl/card_door_access_controller.sv
// Card door access controller, top level.
// Depends on cdac_pkg, cdac_in_if, cdac_out_if, cdac_cfg_regs and cdac_eval.
//
// Usage: each transfer on i_in is one processing call carrying the current
// millisecond time, a read-ok flag and the card UID. Each call produces
// exactly one transfer on o_out: the doors whose close deadline was reached,
// the door opened by a matching card (if any) and whether the scan was taken.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while the block is idle; an index beyond the register list is ignored.
//
// A call is captured in the input register, evaluated in one pass against the
// door deadlines and last scan time, and written to the result register
// together with the state update. Throughput is one call per cycle while
// o_out is not stalled; the state loop closes within that one evaluation pass.
// When o_out is stalled the result register holds and the input register
// still takes one more call; i_in.ready drops only when both are full.
// Synchronous reset clears the deadlines (all doors inactive), the last scan
// time, both pipeline valids, and loads the register defaults.
module card_door_access_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cdac_in_if.sink                         i_in,
    cdac_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [cdac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdac_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cdac_pkg::*;

    t_cfg     w_cfg;
    t_in_item w_in_item;
    t_result  w_res;
    t_state   w_state_nx;

    logic     r_item_vld;
    t_in_item r_item;
    logic     r_res_vld;
    t_result  r_res;
    t_state   r_state;

    logic     w_res_free;
    logic     w_fire;
    logic     w_in_xfer;

    cdac_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cdac_eval u_eval (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_item  (r_item),
        .o_res   (w_res),
        .o_state (w_state_nx)
    );

    assign w_in_item.now_ms   = i_in.now_ms;
    assign w_in_item.read_ok  = i_in.read_ok;
    assign w_in_item.card_uid = i_in.card_uid;

    assign w_res_free = !r_res_vld || o_out.ready;
    assign w_fire     = r_item_vld && w_res_free;
    assign i_in.ready = !r_item_vld || w_res_free;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_res_vld  <= 1'b0;
            r_state    <= '0;
        end else begin
            if (w_in_xfer)
                r_item_vld <= 1'b1;
            else if (w_fire)
                r_item_vld <= 1'b0;

            if (w_fire)
                r_res_vld <= 1'b1;
            else if (o_out.ready)
                r_res_vld <= 1'b0;

            // advance state only when the call moves into the result register
            if (w_fire)
                r_state <= w_state_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer)
            r_item <= w_in_item;
        if (w_fire)
            r_res <= w_res;
    end

    assign o_out.valid      = r_res_vld;
    assign o_out.close_mask = r_res.close_mask;
    assign o_out.open_valid = r_res.open_valid;
    assign o_out.open_door  = r_res.open_door;
    assign o_out.scan_taken = r_res.scan_taken;

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("state changed without an evaluated call");

    a_open_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (!r_res.open_valid || r_res.scan_taken))
        else $error("door opened without taking the scan");

    a_open_door_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.open_valid) |->
            ({1'b0, r_res.open_door} < (DOOR_CODE_W+1)'(DOOR_COUNT)))
        else $error("opened door index out of range");

    a_stage_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item_vld && !r_res_vld) |=> r_res_vld)
        else $error("pending call not moved to result register");

    a_scan_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.scan_taken) |=>
            (r_state.last_scan == $past(r_item.now_ms[TIME_BITS-1:0])))
        else $error("last scan time not updated on taken scan");
endmodule

>>> hdl/cdac_cfg_regs.sv
// Configuration register file written through the plain write port.
// Depends on cdac_pkg (t_cfg, register codes, reset values).
module cdac_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cdac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cdac_pkg::t_cfg                  o_cfg
);
    import cdac_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MONITOR_ENABLE: n_cfg.monitor_enable   = i_cfg_data[0];
                CFG_SCAN_INTERVAL:  n_cfg.scan_interval_ms = i_cfg_data[MS_W-1:0];
                CFG_OPEN_TIME:      n_cfg.open_time_ms     = i_cfg_data[MS_W-1:0];
                CFG_USER_UID_A:     n_cfg.user_uid[0]      = i_cfg_data[UID_W-1:0];
                CFG_USER_UID_B:     n_cfg.user_uid[1]      = i_cfg_data[UID_W-1:0];
                CFG_USER_UID_C:     n_cfg.user_uid[2]      = i_cfg_data[UID_W-1:0];
                CFG_USER_DOOR_MAP:
                    n_cfg.user_door_map = i_cfg_data[UID_SLOTS*DOOR_CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.monitor_enable   <= 1'b0;
            r_cfg.scan_interval_ms <= RST_SCAN_INTERVAL;
            r_cfg.open_time_ms     <= RST_OPEN_TIME;
            r_cfg.user_uid[0]      <= RST_UID_A;
            r_cfg.user_uid[1]      <= RST_UID_B;
            r_cfg.user_uid[2]      <= RST_UID_C;
            r_cfg.user_door_map    <= RST_DOOR_MAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> hdl/cdac_eval.sv
// Single-pass evaluation of one call: deadline closes, scan gating, UID match
// and new door deadline. Pure logic. Depends on cdac_pkg.
module cdac_eval (
    input  cdac_pkg::t_cfg     i_cfg,
    input  cdac_pkg::t_state   i_state,
    input  cdac_pkg::t_in_item i_item,
    output cdac_pkg::t_result  o_res,
    output cdac_pkg::t_state   o_state
);
    import cdac_pkg::*;

    t_time                  w_now;
    t_time                  w_elapsed;
    t_time                  w_new_deadline;
    logic [DOOR_COUNT-1:0]  w_close;
    logic                   w_take;
    logic                   w_found;
    logic [DOOR_CODE_W-1:0] w_door;
    logic                   w_open;

    assign w_now          = i_item.now_ms[TIME_BITS-1:0];
    assign w_elapsed      = w_now - i_state.last_scan;
    assign w_take         = i_cfg.monitor_enable &&
                            (w_elapsed >= TIME_BITS'(i_cfg.scan_interval_ms));
    assign w_new_deadline = w_now + TIME_BITS'(i_cfg.open_time_ms);

    // first matching entry wins, even when its door code opens nothing
    always_comb begin
        w_found = 1'b0;
        w_door  = '0;
        for (int e = 0; e < USER_ENTRIES; e++) begin
            if (!w_found && (i_item.card_uid == i_cfg.user_uid[e])) begin
                w_found = 1'b1;
                w_door  = i_cfg.user_door_map[e*DOOR_CODE_W +: DOOR_CODE_W];
            end
        end
    end

    assign w_open = w_take && i_item.read_ok && w_found &&
                    ({1'b0, w_door} < (DOOR_CODE_W+1)'(DOOR_COUNT));

    always_comb begin
        o_state.last_scan = w_take ? w_now : i_state.last_scan;
        for (int d = 0; d < DOOR_COUNT; d++) begin
            // zero means inactive; the compare is plain unsigned, not modular
            w_close[d] = (i_state.deadline[d] != '0) && (w_now >= i_state.deadline[d]);
            o_state.deadline[d] = w_close[d] ? '0 : i_state.deadline[d];
            if (w_open && (w_door == DOOR_CODE_W'(d)))
                o_state.deadline[d] = w_new_deadline;
        end
    end

    for (genvar b = 0; b < CLOSE_W; b++) begin : g_mask
        if (b < DOOR_COUNT) begin : g_door
            assign o_res.close_mask[b] = w_close[b];
        end else begin : g_none
            assign o_res.close_mask[b] = 1'b0;
        end
    end

    assign o_res.open_valid = w_open;
    assign o_res.open_door  = w_open ? w_door : '0;
    assign o_res.scan_taken = w_take;
endmodule

>>> dv/cdac_access_checker.sv
// Checker for the card door access controller: tracks register writes, predicts
// one result per accepted call and compares it with each result transfer.
// Depends on cdac_pkg, cdac_in_if and cdac_out_if.
module cdac_access_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cdac_in_if                              in_ch,
    cdac_out_if                             out_ch,
    input  logic                            i_cfg_we,
    input  logic [cdac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cdac_pkg::*;

    // shadow registers
    logic                             mon_en;
    logic [MS_W-1:0]                  scan_ivl;
    logic [MS_W-1:0]                  open_ms;
    logic [UID_W-1:0]                 uid_tab [UID_SLOTS];
    logic [UID_SLOTS*DOOR_CODE_W-1:0] door_map;

    // shadow state
    t_time door_deadline [DOOR_COUNT];
    t_time last_scan;

    t_result due_results [$];
    int      errors = 0;

    assign o_fail_count = errors;

    function automatic t_result predict_call(t_time now, logic ok, logic [UID_W-1:0] uid);
        t_result                res;
        t_time                  since;
        logic                   hit;
        logic [DOOR_CODE_W-1:0] code;
        res   = '0;
        hit   = 1'b0;
        for (int d = 0; d < DOOR_COUNT; d++) begin
            // plain unsigned compare; deadline 0 means inactive
            if (door_deadline[d] != '0 && now >= door_deadline[d]) begin
                res.close_mask[d] = 1'b1;
                door_deadline[d]  = '0;
            end
        end
        since = now - last_scan;
        if (mon_en && since >= t_time'(scan_ivl)) begin
            last_scan      = now;
            res.scan_taken = 1'b1;
            if (ok) begin
                for (int e = 0; e < USER_ENTRIES; e++) begin
                    if (!hit && uid == uid_tab[e]) begin
                        // first match ends the search even if its door code is unused
                        hit  = 1'b1;
                        code = door_map[2*e +: 2];
                        if (code < DOOR_COUNT) begin
                            door_deadline[code] = now + t_time'(open_ms);
                            res.open_valid      = 1'b1;
                            res.open_door       = code;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            mon_en     = 1'b0;
            scan_ivl   = RST_SCAN_INTERVAL;
            open_ms    = RST_OPEN_TIME;
            uid_tab[0] = RST_UID_A;
            uid_tab[1] = RST_UID_B;
            uid_tab[2] = RST_UID_C;
            door_map   = RST_DOOR_MAP;
            for (int d = 0; d < DOOR_COUNT; d++) door_deadline[d] = '0;
            last_scan  = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MONITOR_ENABLE: mon_en     = i_cfg_data[0];
                    CFG_SCAN_INTERVAL:  scan_ivl   = i_cfg_data[MS_W-1:0];
                    CFG_OPEN_TIME:      open_ms    = i_cfg_data[MS_W-1:0];
                    CFG_USER_UID_A:     uid_tab[0] = i_cfg_data;
                    CFG_USER_UID_B:     uid_tab[1] = i_cfg_data;
                    CFG_USER_UID_C:     uid_tab[2] = i_cfg_data;
                    CFG_USER_DOOR_MAP:  door_map   = i_cfg_data[UID_SLOTS*DOOR_CODE_W-1:0];
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to the call accepted at this edge
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %0h %0h %0h %0h",
                             $time, out_ch.close_mask, out_ch.open_valid, out_ch.open_door,
                             out_ch.scan_taken);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("close_mask", 32'(want.close_mask), 32'(out_ch.close_mask));
                    check_field("open_valid", 32'(want.open_valid), 32'(out_ch.open_valid));
                    check_field("open_door",  32'(want.open_door),  32'(out_ch.open_door));
                    check_field("scan_taken", 32'(want.scan_taken), 32'(out_ch.scan_taken));
                end
            end
            if (in_ch.valid && in_ch.ready)
                due_results.push_back(predict_call(in_ch.now_ms, in_ch.read_ok, in_ch.card_uid));
        end
        o_pending <= due_results.size();
    end

endmodule

>>> dv/tb_card_door_access_controller.sv
// Testbench top for the card door access controller: clock, reset, directed
// and random calls, register phases, stalls and verdict.
// Depends on cdac_pkg, cdac_in_if, cdac_out_if, the block and cdac_access_checker.
module tb_card_door_access_controller;
    import cdac_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int PHASE_CALLS  = 240;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PCT     = 23;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   fail_count;
    int   pending;
    bit   idle_on;
    bit   hold_req;

    logic [UID_W-1:0] uid_copy [UID_SLOTS];
    t_time            now_cur;

    cdac_in_if  call_ch ();
    cdac_out_if res_ch ();

    card_door_access_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (call_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cdac_access_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (call_ch),
        .out_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                for (int k = 1; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_call(t_time now, logic ok, logic [UID_W-1:0] uid);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            call_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        call_ch.valid    <= 1'b1;
        call_ch.now_ms   <= now;
        call_ch.read_ok  <= ok;
        call_ch.card_uid <= uid;
        @(posedge i_clk);
        while (!call_ch.ready) @(posedge i_clk);
    endtask

    // drop valid and hold until every result is back
    task automatic drain_calls();
        call_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_call(int unsigned step_max);
        int unsigned      r;
        logic [UID_W-1:0] uid;
        r = $urandom_range(99);
        if (r < 3)
            now_cur = $urandom();
        else if (r < 5)
            now_cur = 32'hFFFF_FF00 | $urandom_range(255);
        else
            now_cur = now_cur + $urandom_range(0, step_max);
        r = $urandom_range(99);
        if (r < 55)
            uid = uid_copy[$urandom_range(UID_SLOTS-1)];
        else if (r < 70)
            uid = uid_copy[$urandom_range(UID_SLOTS-1)] ^ (32'h1 << $urandom_range(31));
        else
            uid = $urandom();
        send_call(now_cur, $urandom_range(99) < 85, uid);
    endtask

    initial begin
        logic [MS_W-1:0] ivl;
        logic [MS_W-1:0] open_t;
        int unsigned     step_max;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        call_ch.valid    <= 1'b0;
        call_ch.now_ms   <= '0;
        call_ch.read_ok  <= 1'b0;
        call_ch.card_uid <= '0;
        idle_on  = 1'b0;
        hold_req = 1'b0;
        uid_copy[0] = RST_UID_A;
        uid_copy[1] = RST_UID_B;
        uid_copy[2] = RST_UID_C;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, monitoring off first
        send_call(32'd5000, 1'b1, RST_UID_A);
        drain_calls();
        write_reg(CFG_MONITOR_ENABLE, 32'd1);
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        send_call(32'd0,     1'b1, RST_UID_A);   // interval not yet passed
        send_call(32'd1000,  1'b1, RST_UID_A);   // open door 0
        send_call(32'd1500,  1'b1, RST_UID_B);
        send_call(32'd2000,  1'b1, RST_UID_B);   // open door 1
        send_call(32'd3000,  1'b0, RST_UID_C);   // scan taken without a card
        send_call(32'd6000,  1'b1, 32'h0);       // door 0 closes
        send_call(32'd7000,  1'b1, RST_UID_A);
        send_call(32'd12000, 1'b1, RST_UID_A);   // close and reopen door 0
        send_call(32'd13000, 1'b1, RST_UID_C);
        drain_calls();
        write_reg(CFG_OPEN_TIME, 32'd16);
        write_reg(CFG_SCAN_INTERVAL, 32'd0);
        send_call(32'hFFFF_FFF0, 1'b1, RST_UID_B);    // deadline wraps to zero
        send_call(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_call(32'hFFFF_FFFF, 1'b1, RST_UID_A);    // deadline past the wrap
        send_call(32'h8000_0000, 1'b0, 32'h0);        // closes at once
        drain_calls();
        write_reg(CFG_USER_DOOR_MAP, 32'b10_01_11);
        write_reg(CFG_USER_UID_B, RST_UID_A);
        uid_copy[1] = RST_UID_A;
        send_call(32'h8000_0100, 1'b1, RST_UID_A);    // unused door code stops matching
        send_call(32'h8000_0200, 1'b1, RST_UID_C);
        send_call(32'h8000_0300, 1'b0, RST_UID_C);
        drain_calls();
        write_reg(CFG_SCAN_INTERVAL, 32'hFFFF);
        write_reg(CFG_OPEN_TIME, 32'hFFFF);
        send_call(32'h8000_0400, 1'b1, RST_UID_C);
        send_call(32'h8001_0300, 1'b1, RST_UID_C);
        now_cur = 32'h8001_0300;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_calls();
            case (p)
                1: begin
                    ivl    = '0;
                    open_t = '0;
                end
                6: begin
                    ivl    = 16'hFFFF;
                    open_t = 16'hFFFF;
                end
                default: begin
                    ivl    = MS_W'($urandom_range(1, 40));
                    open_t = MS_W'($urandom_range(1, 100));
                end
            endcase
            idle_on = (p != 4);
            for (int e = 0; e < UID_SLOTS; e++) begin
                // duplicates exercise first-match priority
                if (e > 0 && $urandom_range(99) < 20)
                    uid_copy[e] = uid_copy[e-1];
                else
                    uid_copy[e] = $urandom();
            end
            write_reg(CFG_MONITOR_ENABLE, (p != 5) ? 32'd1 : 32'd0);
            write_reg(CFG_SCAN_INTERVAL, CFG_DATA_W'(ivl));
            write_reg(CFG_OPEN_TIME, CFG_DATA_W'(open_t));
            write_reg(CFG_USER_UID_A, uid_copy[0]);
            write_reg(CFG_USER_UID_B, uid_copy[1]);
            write_reg(CFG_USER_UID_C, uid_copy[2]);
            write_reg(CFG_USER_DOOR_MAP, $urandom_range(63));
            step_max = ivl + ivl / 2 + 8;
            for (int n = 0; n < PHASE_CALLS; n++) begin
                if (p == 2 && n == 40) hold_req = 1'b1;
                if (p == 3 && n == 120) drain_calls();
                random_call(step_max);
            end
        end

        call_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
